[rtl/gnic_pkg.sv]
// ============================================================================
// gnic_pkg
// Shared types and constants of the grid neighbour index calculator.
// ============================================================================
package gnic_pkg;

    // Field widths
    localparam int CELL_W     = 24;     // linear cell index
    localparam int DIM_W      = 13;     // grid_rows / grid_cols registers
    localparam int CODE_W     = 16;     // packed offset codes
    localparam int OFS_W      = 2;      // one signed offset
    localparam int SLOT_COUNT = 8;      // neighbour slots on the result
    localparam int MASK_W     = SLOT_COUNT;

    // Stream payload widths (whole bytes)
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = SLOT_COUNT * CELL_W + MASK_W;

    // Divider layout: quotient bits resolved per stage and stage count
    localparam int STEP_BITS  = 4;
    localparam int DIV_STAGES = CELL_W / STEP_BITS;

    // Internal arithmetic widths
    localparam int ROW_W = CELL_W + 2;  // signed neighbour row
    localparam int COL_W = DIM_W + 2;   // signed neighbour column
    localparam int LIN_W = CELL_W + 3;  // signed neighbour linear index

    // Parameter defaults
    localparam int MAX_DIM_DEF    = 4096;
    localparam int NEIGHBOURS_DEF = 8;

    // Register reset values
    localparam logic [DIM_W-1:0]  GRID_ROWS_RST = 13'd1024;
    localparam logic [DIM_W-1:0]  GRID_COLS_RST = 13'd1024;
    localparam logic [CODE_W-1:0] ROW_CODES_RST = 16'h543F;
    localparam logic [CODE_W-1:0] COL_CODES_RST = 16'h4DD3;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_GRID_ROWS = 2'd0,
        CFG_GRID_COLS = 2'd1,
        CFG_ROW_CODES = 2'd2,
        CFG_COL_CODES = 2'd3
    } cfg_index_t;

    // Payload carried through the divider stages
    typedef struct packed {
        logic [CELL_W-1:0] idx;     // original cell index
        logic [CELL_W-1:0] dvd;     // dividend bits still to consume, msb first
        logic [CELL_W-1:0] quot;    // partial quotient (row)
        logic [DIM_W-1:0]  rem;     // partial remainder (column)
    } div_stage_t;

    typedef struct packed {
        logic [SLOT_COUNT-1:0][CELL_W-1:0] nbr;
        logic [MASK_W-1:0]                 mask;
    } result_t;

endpackage

[rtl/grid_neighbour_index_calc.sv]
// Pipeline: an input transaction passes through 6 restoring-divider stages
//   of 4 quotient bits each, then one bounds stage that registers the result.
// Throughput: one cell index per cycle, set by the divider pipeline, unless the
// output stalls. Stages advance independently, so bubbles collapse in a stall.
// Reset clears all stage valid bits and loads the register defaults.
// ============================================================================
// grid_neighbour_index_calc
// Splits a row-major cell index into row and column and returns up to eight
// bounds-checked neighbour indices with a valid mask.
// ============================================================================
module grid_neighbour_index_calc #(
    parameter int MAX_DIM    = gnic_pkg::MAX_DIM_DEF,
    parameter int NEIGHBOURS = gnic_pkg::NEIGHBOURS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,

    // configuration
    input  logic                                cfg_we,
    input  logic [gnic_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [gnic_pkg::CFG_DATA_W-1:0]     cfg_data,

    // input stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [gnic_pkg::IN_DATA_W-1:0]      s_axis_tdata,   // [23:0] cell_index

    // result stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [23:0] neighbour_0, [47:24] neighbour_1, ... [191:168] neighbour_7,
    // [199:192] valid_mask
    output logic [gnic_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);

    localparam int LAST = gnic_pkg::DIV_STAGES;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [gnic_pkg::DIM_W-1:0]  grid_rows_reg;
    logic [gnic_pkg::DIM_W-1:0]  grid_cols_reg;
    logic [gnic_pkg::CODE_W-1:0] row_codes_reg;
    logic [gnic_pkg::CODE_W-1:0] col_codes_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_rows_reg <= gnic_pkg::GRID_ROWS_RST;
            grid_cols_reg <= gnic_pkg::GRID_COLS_RST;
            row_codes_reg <= gnic_pkg::ROW_CODES_RST;
            col_codes_reg <= gnic_pkg::COL_CODES_RST;
        end
        else if (cfg_we)
        begin
            case (gnic_pkg::cfg_index_t'(cfg_index))
                gnic_pkg::CFG_GRID_ROWS: grid_rows_reg <= cfg_data[gnic_pkg::DIM_W-1:0];
                gnic_pkg::CFG_GRID_COLS: grid_cols_reg <= cfg_data[gnic_pkg::DIM_W-1:0];
                gnic_pkg::CFG_ROW_CODES: row_codes_reg <= cfg_data;
                gnic_pkg::CFG_COL_CODES: col_codes_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Saturate dimensions to MAX_DIM
    logic [gnic_pkg::DIM_W-1:0] rows_eff;
    logic [gnic_pkg::DIM_W-1:0] cols_eff;
    logic                       dims_ok;

    assign rows_eff = ({{(32-gnic_pkg::DIM_W){1'b0}}, grid_rows_reg} > 32'(MAX_DIM))
                    ? gnic_pkg::DIM_W'(MAX_DIM) : grid_rows_reg;
    assign cols_eff = ({{(32-gnic_pkg::DIM_W){1'b0}}, grid_cols_reg} > 32'(MAX_DIM))
                    ? gnic_pkg::DIM_W'(MAX_DIM) : grid_cols_reg;
    assign dims_ok  = (rows_eff != '0) && (cols_eff != '0);

    // ------------------------------------------------------------------
    // Pipeline control: stage LAST is the result register
    // ------------------------------------------------------------------
    logic [LAST:0] valid_reg;
    logic [LAST:0] stage_adv;
    logic [LAST:0] stage_in_valid;

    always_comb
    begin
        stage_adv[LAST] = !valid_reg[LAST] || m_axis_tready;
        for (int i = LAST - 1; i >= 0; i--)
        begin
            stage_adv[i] = !valid_reg[i] || stage_adv[i+1];
        end
    end

    assign stage_in_valid = {valid_reg[LAST-1:0], s_axis_tvalid};
    assign s_axis_tready  = stage_adv[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
        begin
            for (int i = 0; i <= LAST; i++)
            begin
                if (stage_adv[i])
                    valid_reg[i] <= stage_in_valid[i];
            end
        end
    end

    // ------------------------------------------------------------------
    // Restoring divider: idx / cols, STEP_BITS quotient bits per stage
    // ------------------------------------------------------------------
    gnic_pkg::div_stage_t div_reg  [LAST];
    gnic_pkg::div_stage_t div_in   [LAST];
    gnic_pkg::div_stage_t div_next [LAST];

    always_comb
    begin
        div_in[0].idx  = s_axis_tdata[gnic_pkg::CELL_W-1:0];
        div_in[0].dvd  = s_axis_tdata[gnic_pkg::CELL_W-1:0];
        div_in[0].quot = '0;
        div_in[0].rem  = '0;
        for (int i = 1; i < LAST; i++)
        begin
            div_in[i] = div_reg[i-1];
        end
    end

    for (genvar g = 0; g < LAST; g++)
    begin : g_div
        always_comb
        begin
            logic [gnic_pkg::DIM_W:0] trial;
            logic [gnic_pkg::DIM_W:0] diff;
            div_next[g] = div_in[g];
            for (int j = 0; j < gnic_pkg::STEP_BITS; j++)
            begin
                trial = {div_next[g].rem, div_next[g].dvd[gnic_pkg::CELL_W-1]};
                diff  = trial - {1'b0, cols_eff};
                div_next[g].dvd = {div_next[g].dvd[gnic_pkg::CELL_W-2:0], 1'b0};
                if (trial >= {1'b0, cols_eff})
                begin
                    div_next[g].rem  = diff[gnic_pkg::DIM_W-1:0];
                    div_next[g].quot = {div_next[g].quot[gnic_pkg::CELL_W-2:0], 1'b1};
                end
                else
                begin
                    div_next[g].rem  = trial[gnic_pkg::DIM_W-1:0];
                    div_next[g].quot = {div_next[g].quot[gnic_pkg::CELL_W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (stage_adv[g] && stage_in_valid[g])
                div_reg[g] <= div_next[g];
        end
    end

    // ------------------------------------------------------------------
    // Neighbour stage: offsets, bounds, linear index
    // ------------------------------------------------------------------
    gnic_pkg::div_stage_t dq;
    gnic_pkg::result_t    result_next;
    gnic_pkg::result_t    result_reg;

    assign dq = div_reg[LAST-1];

    always_comb
    begin
        logic signed [gnic_pkg::OFS_W-1:0] dr;
        logic signed [gnic_pkg::OFS_W-1:0] dc;
        logic signed [gnic_pkg::ROW_W-1:0] r;
        logic signed [gnic_pkg::COL_W-1:0] c;
        logic signed [gnic_pkg::LIN_W-1:0] row_step;
        logic signed [gnic_pkg::LIN_W-1:0] lin;
        logic                              ok;
        result_next = '0;
        for (int n = 0; n < gnic_pkg::SLOT_COUNT; n++)
        begin
            dr = $signed(row_codes_reg[2*n +: gnic_pkg::OFS_W]);
            dc = $signed(col_codes_reg[2*n +: gnic_pkg::OFS_W]);
            r  = $signed({2'b00, dq.quot}) + gnic_pkg::ROW_W'(dr);
            c  = $signed({2'b00, dq.rem}) + gnic_pkg::COL_W'(dc);
            // lin = idx + dr*cols + dc equals r*cols + c for an in-bounds neighbour
            row_step = gnic_pkg::LIN_W'(dr)
                     * $signed({{(gnic_pkg::LIN_W-gnic_pkg::DIM_W){1'b0}}, cols_eff});
            lin = $signed({3'b000, dq.idx}) + row_step + gnic_pkg::LIN_W'(dc);
            ok  = dims_ok && (n < NEIGHBOURS)
               && !r[gnic_pkg::ROW_W-1] && !c[gnic_pkg::COL_W-1]
               && (r < $signed({{(gnic_pkg::ROW_W-gnic_pkg::DIM_W){1'b0}}, rows_eff}))
               && (c < $signed({2'b00, cols_eff}))
               && (lin[gnic_pkg::LIN_W-1:gnic_pkg::CELL_W] == '0);
            if (ok)
            begin
                result_next.nbr[n]  = lin[gnic_pkg::CELL_W-1:0];
                result_next.mask[n] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_adv[LAST] && stage_in_valid[LAST])
            result_reg <= result_next;
    end

    assign m_axis_tvalid = valid_reg[LAST];
    assign m_axis_tdata  = {result_reg.mask, result_reg.nbr[7], result_reg.nbr[6],
                            result_reg.nbr[5], result_reg.nbr[4], result_reg.nbr[3],
                            result_reg.nbr[2], result_reg.nbr[1], result_reg.nbr[0]};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_accept_loads_stage0: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> valid_reg[0])
        else $error("accepted transaction did not enter the first divider stage");

    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[LAST-1] && cols_eff != '0) |-> (dq.rem < cols_eff))
        else $error("divider remainder not below column count");

    a_empty_grid_no_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !dims_ok) |-> (result_reg.mask == '0))
        else $error("neighbour flagged valid on an empty grid");

    a_unused_slots_clear: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> ((result_reg.mask >> NEIGHBOURS) == '0))
        else $error("mask bit set for an unused neighbour slot");

    a_stall_holds_stage: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[LAST] && !m_axis_tready) |=> valid_reg[LAST] && $stable(result_reg))
        else $error("stalled result changed");

endmodule
